@@ design/polar_least_squares_line_fit_assert.svh @@
// Assertion macros for the polar line fit block.
`ifndef POLAR_LEAST_SQUARES_LINE_FIT_ASSERT_SVH
`define POLAR_LEAST_SQUARES_LINE_FIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PLSQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PLSQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/plsq_pkg.sv @@
// Shared constants, command/status types and the CORDIC angle table.
package plsq_pkg;

    localparam int MAX_POINTS    = 1024;
    localparam int COORD_W       = 16;
    localparam int CORDIC_STAGES = 16;

    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int SUM_W   = COORD_W + $clog2(MAX_POINTS);
    localparam int SQ_W    = 2 * COORD_W + $clog2(MAX_POINTS);
    localparam int HI_SPLIT = SQ_W / 2;
    localparam int CW      = 34;
    localparam int MA_W    = SUM_W + 1;
    localparam int MB_W    = CW;
    localparam int P_W     = MA_W + MB_W;
    localparam int M_W     = 64;
    localparam int ANG_W   = 16;
    localparam int DIST_W  = 17;
    localparam int Q_W     = 18;
    localparam int DVD_W   = M_W + 1;
    localparam int FRAC    = 30;
    localparam int ANG_SH  = 16;
    localparam int ALPHA_SH = 17;
    localparam int IDX_W   = $clog2((Q_W > CORDIC_STAGES) ? Q_W : CORDIC_STAGES);

    localparam logic signed [CW-1:0] GAIN_Q30  = CW'(652032874);
    localparam logic signed [CW-1:0] HALF_PI_U = CW'(64'd1 << 30);
    localparam logic signed [CW-1:0] PI_U      = CW'(64'd1 << 31);
    localparam logic signed [CW-1:0] ALPHA_RND = CW'(64'd1 << (ALPHA_SH - 1));
    localparam logic signed [P_W-1:0] ROUND_HALF = P_W'(64'd1 << (FRAC - 1));
    localparam logic [DIST_W-1:0] Q_SAT = DIST_W'(65536);

    typedef enum logic [4:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_ROT_PT,
        ACT_ROT_FIT,
        ACT_CSTEP_ROT,
        ACT_CSTEP_VEC,
        ACT_ROT_FIN,
        ACT_SET_X,
        ACT_SET_Y,
        ACT_ACC_XX,
        ACT_ACC_YY,
        ACT_ACC_XY,
        ACT_OVF,
        ACT_MOM_LD,
        ACT_MOM_HI,
        ACT_MOM_SET,
        ACT_SET_AX,
        ACT_MAG,
        ACT_NORM,
        ACT_ALPHA_ZERO,
        ACT_VEC_INIT,
        ACT_ALPHA,
        ACT_NUM_LD,
        ACT_NUM_ADD,
        ACT_DIV_MAG,
        ACT_DIV_BIAS,
        ACT_DIV_STEP,
        ACT_OUT
    } act_t;

    typedef enum logic [3:0] {
        MS_XX,
        MS_YY,
        MS_XY,
        MS_RC,
        MS_RS,
        MS_NLO,
        MS_NHI,
        MS_SQ,
        MS_SXC,
        MS_SYS
    } msel_t;

    typedef struct packed {
        act_t             act;
        logic             mul_en;
        msel_t            msel;
        logic [IDX_W-1:0] idx;
    } cmd_t;

    typedef struct packed {
        logic mode;
        logic last;
        logic can_acc;
        logic degen;
        logic big;
        logic out_free;
    } st_t;

    // atan(2^-i) in units of pi/2^31
    function automatic logic signed [CW-1:0] atan_unit(input logic [IDX_W-1:0] i);
        logic signed [CW-1:0] v;
        case (i)
            5'd0:    v = CW'(536870912);
            5'd1:    v = CW'(316933406);
            5'd2:    v = CW'(167458907);
            5'd3:    v = CW'(85004756);
            5'd4:    v = CW'(42667331);
            5'd5:    v = CW'(21354465);
            5'd6:    v = CW'(10679838);
            5'd7:    v = CW'(5340245);
            5'd8:    v = CW'(2670163);
            5'd9:    v = CW'(1335087);
            5'd10:   v = CW'(667544);
            5'd11:   v = CW'(333772);
            5'd12:   v = CW'(166886);
            5'd13:   v = CW'(83443);
            5'd14:   v = CW'(41722);
            5'd15:   v = CW'(20861);
            5'd16:   v = CW'(10430);
            5'd17:   v = CW'(5215);
            5'd18:   v = CW'(2608);
            5'd19:   v = CW'(1304);
            5'd20:   v = CW'(652);
            5'd21:   v = CW'(326);
            5'd22:   v = CW'(163);
            5'd23:   v = CW'(81);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ design/plsq_ctrl.sv @@
// Sequencer for point accumulation and the end-of-segment fit.
module plsq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  plsq_pkg::st_t   st,
    output plsq_pkg::cmd_t  cmd
);
    import plsq_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_P_RINIT,
        S_P_RSTEP,
        S_P_RFIN,
        S_P_MULX,
        S_P_SETX,
        S_P_SETY,
        S_ACC,
        S_A_YY,
        S_A_XY,
        S_A_END,
        S_F_M0,
        S_F_M1,
        S_F_M2,
        S_F_M3,
        S_F_AX,
        S_F_MAG,
        S_F_NORM,
        S_F_VINIT,
        S_F_VSTEP,
        S_F_ALPHA,
        S_F_RINIT,
        S_F_RSTEP,
        S_F_RFIN,
        S_F_NUM0,
        S_F_NUM1,
        S_F_NUM2,
        S_F_DMAG,
        S_F_DBIAS,
        S_F_DSTEP,
        S_F_OUT
    } state_t;

    localparam logic [IDX_W-1:0] LAST_STAGE = IDX_W'(CORDIC_STAGES - 1);
    localparam logic [IDX_W-1:0] LAST_MOM   = IDX_W'(2);
    localparam logic [IDX_W-1:0] TOP_QBIT   = IDX_W'(Q_W - 1);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '{act: ACT_NONE, mul_en: 1'b0, msel: MS_XX, idx: cnt_reg};
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.act    = ACT_LOAD;
                    state_next = st.mode ? S_P_RINIT : S_ACC;
                end
            end
            S_P_RINIT:
            begin
                cmd.act    = ACT_ROT_PT;
                cnt_next   = '0;
                state_next = S_P_RSTEP;
            end
            S_P_RSTEP:
            begin
                cmd.act = ACT_CSTEP_ROT;
                if (cnt_reg == LAST_STAGE)
                    state_next = S_P_RFIN;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_P_RFIN:
            begin
                cmd.act    = ACT_ROT_FIN;
                state_next = S_P_MULX;
            end
            S_P_MULX:
            begin
                cmd.mul_en = 1'b1;
                cmd.msel   = MS_RC;
                state_next = S_P_SETX;
            end
            S_P_SETX:
            begin
                cmd.act    = ACT_SET_X;
                cmd.mul_en = 1'b1;
                cmd.msel   = MS_RS;
                state_next = S_P_SETY;
            end
            S_P_SETY:
            begin
                cmd.act    = ACT_SET_Y;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                if (st.can_acc)
                begin
                    cmd.mul_en = 1'b1;
                    cmd.msel   = MS_XX;
                    state_next = S_A_YY;
                end
                else
                begin
                    cmd.act    = ACT_OVF;
                    cnt_next   = '0;
                    state_next = st.last ? S_F_M0 : S_IDLE;
                end
            end
            S_A_YY:
            begin
                cmd.act    = ACT_ACC_XX;
                cmd.mul_en = 1'b1;
                cmd.msel   = MS_YY;
                state_next = S_A_XY;
            end
            S_A_XY:
            begin
                cmd.act    = ACT_ACC_YY;
                cmd.mul_en = 1'b1;
                cmd.msel   = MS_XY;
                state_next = S_A_END;
            end
            S_A_END:
            begin
                cmd.act    = ACT_ACC_XY;
                cnt_next   = '0;
                state_next = st.last ? S_F_M0 : S_IDLE;
            end
            // moment k = cnt: n*S split in halves, minus the square of sums
            S_F_M0:
            begin
                cmd.mul_en = 1'b1;
                cmd.msel   = MS_NLO;
                state_next = S_F_M1;
            end
            S_F_M1:
            begin
                cmd.act    = ACT_MOM_LD;
                cmd.mul_en = 1'b1;
                cmd.msel   = MS_NHI;
                state_next = S_F_M2;
            end
            S_F_M2:
            begin
                cmd.act    = ACT_MOM_HI;
                cmd.mul_en = 1'b1;
                cmd.msel   = MS_SQ;
                state_next = S_F_M3;
            end
            S_F_M3:
            begin
                cmd.act = ACT_MOM_SET;
                if (cnt_reg == LAST_MOM)
                    state_next = S_F_AX;
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_F_M0;
                end
            end
            S_F_AX:
            begin
                cmd.act    = ACT_SET_AX;
                state_next = S_F_MAG;
            end
            S_F_MAG:
            begin
                cmd.act    = ACT_MAG;
                state_next = S_F_NORM;
            end
            S_F_NORM:
            begin
                if (st.degen)
                begin
                    cmd.act    = ACT_ALPHA_ZERO;
                    state_next = S_F_RINIT;
                end
                else if (st.big)
                    cmd.act = ACT_NORM;
                else
                    state_next = S_F_VINIT;
            end
            S_F_VINIT:
            begin
                cmd.act    = ACT_VEC_INIT;
                cnt_next   = '0;
                state_next = S_F_VSTEP;
            end
            S_F_VSTEP:
            begin
                cmd.act = ACT_CSTEP_VEC;
                if (cnt_reg == LAST_STAGE)
                    state_next = S_F_ALPHA;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_F_ALPHA:
            begin
                cmd.act    = ACT_ALPHA;
                state_next = S_F_RINIT;
            end
            S_F_RINIT:
            begin
                cmd.act    = ACT_ROT_FIT;
                cnt_next   = '0;
                state_next = S_F_RSTEP;
            end
            S_F_RSTEP:
            begin
                cmd.act = ACT_CSTEP_ROT;
                if (cnt_reg == LAST_STAGE)
                    state_next = S_F_RFIN;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_F_RFIN:
            begin
                cmd.act    = ACT_ROT_FIN;
                state_next = S_F_NUM0;
            end
            S_F_NUM0:
            begin
                cmd.mul_en = 1'b1;
                cmd.msel   = MS_SXC;
                state_next = S_F_NUM1;
            end
            S_F_NUM1:
            begin
                cmd.act    = ACT_NUM_LD;
                cmd.mul_en = 1'b1;
                cmd.msel   = MS_SYS;
                state_next = S_F_NUM2;
            end
            S_F_NUM2:
            begin
                cmd.act    = ACT_NUM_ADD;
                state_next = S_F_DMAG;
            end
            S_F_DMAG:
            begin
                cmd.act    = ACT_DIV_MAG;
                state_next = S_F_DBIAS;
            end
            S_F_DBIAS:
            begin
                cmd.act    = ACT_DIV_BIAS;
                cnt_next   = TOP_QBIT;
                state_next = S_F_DSTEP;
            end
            S_F_DSTEP:
            begin
                cmd.act = ACT_DIV_STEP;
                if (cnt_reg == '0)
                    state_next = S_F_OUT;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            S_F_OUT:
            begin
                if (st.out_free)
                begin
                    cmd.act    = ACT_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ design/plsq_dp.sv @@
// Datapath: sums, shared multiplier, shared CORDIC, divider and result register.
module plsq_dp (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_wr_en,
    input  logic                                   cfg_wr_data,
    input  logic signed [plsq_pkg::COORD_W-1:0]    coord_a,
    input  logic signed [plsq_pkg::COORD_W-1:0]    coord_b,
    input  logic                                   last_point,
    input  logic                                   out_ready,
    input  plsq_pkg::cmd_t                         cmd,
    output plsq_pkg::st_t                          st,
    output logic                                   out_valid,
    output logic signed [plsq_pkg::ANG_W-1:0]      normal_angle,
    output logic signed [plsq_pkg::DIST_W-1:0]     normal_distance,
    output logic [plsq_pkg::CNT_W-1:0]             point_count,
    output logic                                   degenerate,
    output logic                                   count_overflow
);
    import plsq_pkg::*;

    // architectural state
    logic                     mode_reg;
    logic signed [SUM_W-1:0]  sum_x_reg, sum_y_reg;
    logic signed [SQ_W-1:0]   sum_xx_reg, sum_yy_reg, sum_xy_reg;
    logic [CNT_W-1:0]         pts_reg;
    logic                     ovf_reg;
    logic                     out_valid_reg;

    // working registers
    logic signed [COORD_W-1:0] a_reg, x_reg, y_reg;
    logic [COORD_W-2:0]        rng_reg;
    logic                      last_reg;
    logic signed [CW-1:0]      cx_reg, cy_reg, cz_reg, c_reg, s_reg;
    logic                      flip_reg;
    logic signed [P_W-1:0]     p_reg;
    logic signed [M_W-1:0]     acc_reg, cxx_reg, cyy_reg, cxy_reg;
    logic [M_W-1:0]            mx_reg, my_reg;
    logic                      sx_reg, sy_reg, degen_reg;
    logic signed [ANG_W-1:0]   alpha_reg;
    logic [DVD_W-1:0]          dvd_reg;
    logic [Q_W-1:0]            q_reg;
    logic                      neg_reg;
    logic signed [ANG_W-1:0]   ang_out_reg;
    logic signed [DIST_W-1:0]  dist_out_reg;
    logic [CNT_W-1:0]          cnt_out_reg;
    logic                      degen_out_reg, ovf_out_reg;

    // multiplier operands
    logic signed [MA_W-1:0] ma;
    logic signed [MB_W-1:0] mb;
    logic signed [P_W-1:0]  prod;
    logic signed [SQ_W-1:0] sum_sel;
    logic signed [MB_W-1:0] n_op;

    always_comb
    begin
        case (cmd.idx)
            IDX_W'(0): sum_sel = sum_xx_reg;
            IDX_W'(1): sum_sel = sum_yy_reg;
            default:   sum_sel = sum_xy_reg;
        endcase
    end

    assign n_op = MB_W'($signed({1'b0, pts_reg}));

    always_comb
    begin
        ma = '0;
        mb = '0;
        case (cmd.msel)
            MS_XX:
            begin
                ma = MA_W'(x_reg);
                mb = MB_W'(x_reg);
            end
            MS_YY:
            begin
                ma = MA_W'(y_reg);
                mb = MB_W'(y_reg);
            end
            MS_XY:
            begin
                ma = MA_W'(x_reg);
                mb = MB_W'(y_reg);
            end
            MS_RC:
            begin
                ma = MA_W'($signed({1'b0, rng_reg}));
                mb = c_reg;
            end
            MS_RS:
            begin
                ma = MA_W'($signed({1'b0, rng_reg}));
                mb = s_reg;
            end
            MS_NLO:
            begin
                ma = MA_W'($signed({1'b0, sum_sel[HI_SPLIT-1:0]}));
                mb = n_op;
            end
            MS_NHI:
            begin
                ma = MA_W'($signed(sum_sel[SQ_W-1:HI_SPLIT]));
                mb = n_op;
            end
            MS_SQ:
            begin
                ma = (cmd.idx == IDX_W'(1)) ? MA_W'(sum_y_reg) : MA_W'(sum_x_reg);
                mb = (cmd.idx == IDX_W'(0)) ? MB_W'(sum_x_reg) : MB_W'(sum_y_reg);
            end
            MS_SXC:
            begin
                ma = MA_W'(sum_x_reg);
                mb = c_reg;
            end
            MS_SYS:
            begin
                ma = MA_W'(sum_y_reg);
                mb = s_reg;
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    assign prod = P_W'(ma) * P_W'(mb);

    // one CORDIC micro-rotation; vectoring drives y toward zero
    logic                 c_up;
    logic signed [CW-1:0] xs, ys, at;
    logic signed [CW-1:0] cx_step, cy_step, cz_step;

    always_comb
    begin
        if (cmd.act == ACT_CSTEP_VEC)
            c_up = cy_reg[CW-1] || (cy_reg == '0);
        else
            c_up = !cz_reg[CW-1];
        xs = cx_reg >>> cmd.idx;
        ys = cy_reg >>> cmd.idx;
        at = atan_unit(cmd.idx);
        if (c_up)
        begin
            cx_step = cx_reg - ys;
            cy_step = cy_reg + xs;
            cz_step = cz_reg - at;
        end
        else
        begin
            cx_step = cx_reg + ys;
            cy_step = cy_reg - xs;
            cz_step = cz_reg + at;
        end
    end

    // rotation start angle, folded into [-pi/2, pi/2]
    logic signed [ANG_W-1:0] z_ang;
    logic signed [CW-1:0]    z_src, z_fold;
    logic                    z_flip;

    always_comb
    begin
        z_ang = (cmd.act == ACT_ROT_PT) ? a_reg : alpha_reg;
        z_src = CW'(z_ang) <<< ANG_SH;
        if (z_src > HALF_PI_U)
        begin
            z_fold = z_src - PI_U;
            z_flip = 1'b1;
        end
        else if (z_src < -HALF_PI_U)
        begin
            z_fold = z_src + PI_U;
            z_flip = 1'b1;
        end
        else
        begin
            z_fold = z_src;
            z_flip = 1'b0;
        end
    end

    // polar point scaling: round half up, clamp to coordinate range
    logic signed [P_W-1:0]     rnd, rsh;
    logic signed [COORD_W-1:0] pt_val;

    always_comb
    begin
        rnd = p_reg + ROUND_HALF;
        rsh = rnd >>> FRAC;
        if (rsh > P_W'(2 ** (COORD_W - 1) - 1))
            pt_val = {1'b0, {(COORD_W - 1){1'b1}}};
        else if (rsh < -P_W'(2 ** (COORD_W - 1)))
            pt_val = {1'b1, {(COORD_W - 1){1'b0}}};
        else
            pt_val = rsh[COORD_W-1:0];
    end

    // vectoring start: quadrant pre-rotation when x is negative
    logic                 xneg, yneg;
    logic signed [CW-1:0] mxs, mys, alpha_t;

    assign xneg    = sx_reg && (mx_reg != '0);
    assign yneg    = sy_reg && (my_reg != '0);
    assign mxs     = $signed(mx_reg[CW-1:0]);
    assign mys     = $signed(my_reg[CW-1:0]);
    assign alpha_t = (cz_reg + ALPHA_RND) >>> ALPHA_SH;

    // divider
    logic [DVD_W-1:0]      den_sh;
    logic [DVD_W:0]        diff;
    logic [M_W-1:0]        acc_mag;
    logic [DIST_W-1:0]     q_clip;
    logic signed [DIST_W:0] d_wide;
    logic signed [DIST_W-1:0] d_out;

    assign den_sh  = DVD_W'({pts_reg, {FRAC{1'b0}}}) << cmd.idx;
    assign diff    = {1'b0, dvd_reg} - {1'b0, den_sh};
    assign acc_mag = acc_reg[M_W-1] ? M_W'(-acc_reg) : M_W'(acc_reg);

    always_comb
    begin
        q_clip = (q_reg > Q_W'(Q_SAT)) ? Q_SAT : q_reg[DIST_W-1:0];
        d_wide = neg_reg ? -$signed({1'b0, q_clip}) : $signed({1'b0, q_clip});
        if (d_wide > (DIST_W + 1)'(2 ** (DIST_W - 1) - 1))
            d_out = {1'b0, {(DIST_W - 1){1'b1}}};
        else
            d_out = d_wide[DIST_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            sum_xx_reg    <= '0;
            sum_yy_reg    <= '0;
            sum_xy_reg    <= '0;
            pts_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                mode_reg <= cfg_wr_data;
            // a new result may load in the cycle the previous one transfers
            if (cmd.act == ACT_OUT)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (cmd.act)
                ACT_ACC_XX: sum_xx_reg <= sum_xx_reg + p_reg[SQ_W-1:0];
                ACT_ACC_YY: sum_yy_reg <= sum_yy_reg + p_reg[SQ_W-1:0];
                ACT_ACC_XY:
                begin
                    sum_xy_reg <= sum_xy_reg + p_reg[SQ_W-1:0];
                    sum_x_reg  <= sum_x_reg + SUM_W'(x_reg);
                    sum_y_reg  <= sum_y_reg + SUM_W'(y_reg);
                    pts_reg    <= pts_reg + 1'b1;
                end
                ACT_OVF: ovf_reg <= 1'b1;
                ACT_OUT:
                begin
                    sum_x_reg     <= '0;
                    sum_y_reg     <= '0;
                    sum_xx_reg    <= '0;
                    sum_yy_reg    <= '0;
                    sum_xy_reg    <= '0;
                    pts_reg       <= '0;
                    ovf_reg       <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
            p_reg <= prod;
        case (cmd.act)
            ACT_LOAD:
            begin
                a_reg    <= coord_a;
                x_reg    <= coord_a;
                y_reg    <= coord_b;
                rng_reg  <= coord_b[COORD_W-1] ? '0 : coord_b[COORD_W-2:0];
                last_reg <= last_point;
            end
            ACT_ROT_PT, ACT_ROT_FIT:
            begin
                cx_reg   <= GAIN_Q30;
                cy_reg   <= '0;
                cz_reg   <= z_fold;
                flip_reg <= z_flip;
            end
            ACT_CSTEP_ROT, ACT_CSTEP_VEC:
            begin
                cx_reg <= cx_step;
                cy_reg <= cy_step;
                cz_reg <= cz_step;
            end
            ACT_ROT_FIN:
            begin
                c_reg <= flip_reg ? -cx_reg : cx_reg;
                s_reg <= flip_reg ? -cy_reg : cy_reg;
            end
            ACT_SET_X: x_reg <= pt_val;
            ACT_SET_Y: y_reg <= pt_val;
            ACT_MOM_LD: acc_reg <= M_W'(p_reg);
            ACT_MOM_HI: acc_reg <= acc_reg + (M_W'(p_reg) <<< HI_SPLIT);
            ACT_MOM_SET:
            begin
                case (cmd.idx)
                    IDX_W'(0): cxx_reg <= acc_reg - M_W'(p_reg);
                    IDX_W'(1): cyy_reg <= acc_reg - M_W'(p_reg);
                    default:   cxy_reg <= acc_reg - M_W'(p_reg);
                endcase
            end
            ACT_SET_AX:
            begin
                mx_reg <= cyy_reg - cxx_reg;
                my_reg <= M_W'(0) - (cxy_reg <<< 1);
            end
            ACT_MAG:
            begin
                sx_reg    <= mx_reg[M_W-1];
                sy_reg    <= my_reg[M_W-1];
                mx_reg    <= mx_reg[M_W-1] ? -mx_reg : mx_reg;
                my_reg    <= my_reg[M_W-1] ? -my_reg : my_reg;
                degen_reg <= (mx_reg == '0) && (my_reg == '0);
            end
            ACT_NORM:
            begin
                mx_reg <= mx_reg >> 1;
                my_reg <= my_reg >> 1;
            end
            ACT_VEC_INIT:
            begin
                if (xneg)
                begin
                    cx_reg <= mys;
                    cy_reg <= yneg ? -mxs : mxs;
                    cz_reg <= yneg ? -HALF_PI_U : HALF_PI_U;
                end
                else
                begin
                    cx_reg <= mxs;
                    cy_reg <= yneg ? -mys : mys;
                    cz_reg <= '0;
                end
            end
            ACT_ALPHA:      alpha_reg <= alpha_t[ANG_W-1:0];
            ACT_ALPHA_ZERO: alpha_reg <= '0;
            ACT_NUM_LD:     acc_reg <= M_W'(p_reg);
            ACT_NUM_ADD:    acc_reg <= acc_reg + M_W'(p_reg);
            ACT_DIV_MAG:
            begin
                neg_reg <= acc_reg[M_W-1];
                dvd_reg <= {1'b0, acc_mag};
                q_reg   <= '0;
            end
            ACT_DIV_BIAS: dvd_reg <= dvd_reg + DVD_W'({pts_reg, {(FRAC - 1){1'b0}}});
            ACT_DIV_STEP:
            begin
                if (!diff[DVD_W])
                begin
                    dvd_reg        <= diff[DVD_W-1:0];
                    q_reg[cmd.idx] <= 1'b1;
                end
            end
            ACT_OUT:
            begin
                ang_out_reg   <= alpha_reg;
                dist_out_reg  <= d_out;
                cnt_out_reg   <= pts_reg;
                degen_out_reg <= degen_reg;
                ovf_out_reg   <= ovf_reg;
            end
            default:
            begin
            end
        endcase
    end

    // n stays below 2^31 counts of pi/2^31 scale, no larger check needed
    assign st.mode     = mode_reg;
    assign st.last     = last_reg;
    assign st.can_acc  = (pts_reg < CNT_W'(MAX_POINTS));
    assign st.degen    = degen_reg;
    assign st.big      = (mx_reg[M_W-1:FRAC] != '0) || (my_reg[M_W-1:FRAC] != '0);
    assign st.out_free = !out_valid_reg || out_ready;

    assign out_valid       = out_valid_reg;
    assign normal_angle    = ang_out_reg;
    assign normal_distance = dist_out_reg;
    assign point_count     = cnt_out_reg;
    assign degenerate      = degen_out_reg;
    assign count_overflow  = ovf_out_reg;

endmodule

@@ design/polar_least_squares_line_fit.sv @@
// Top level of the polar-normal-form total least squares line fitter.
// A polar point goes through 16 CORDIC iterations and scaling before it is accumulated.
// A point marked last then runs the fit, which also waits while the result
// register is held: moment products on one shared multiplier, up to 22 normalize shifts,
// two 16-step CORDIC runs (one for zero scatter), 18 divide steps.
// Reset clears the sums, count, overflow flag, mode and the result-valid; no clearing pass.
module polar_least_squares_line_fit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_wr_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [plsq_pkg::COORD_W-1:0] coord_a,
    input  logic signed [plsq_pkg::COORD_W-1:0] coord_b,
    input  logic                                last_point,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [plsq_pkg::ANG_W-1:0]   normal_angle,
    output logic signed [plsq_pkg::DIST_W-1:0]  normal_distance,
    output logic [plsq_pkg::CNT_W-1:0]          point_count,
    output logic                                degenerate,
    output logic                                count_overflow
);
    import plsq_pkg::*;

    `include "polar_least_squares_line_fit_assert.svh"

    cmd_t cmd;
    st_t  st;

    plsq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    plsq_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .coord_a         (coord_a),
        .coord_b         (coord_b),
        .last_point      (last_point),
        .out_ready       (out_ready),
        .cmd             (cmd),
        .st              (st),
        .out_valid       (out_valid),
        .normal_angle    (normal_angle),
        .normal_distance (normal_distance),
        .point_count     (point_count),
        .degenerate      (degenerate),
        .count_overflow  (count_overflow)
    );

    // one point in flight: busy right after each input transfer
    `PLSQ_ASSERT_NEXT(a_busy_after_xfer, clk, rst_n, in_valid && in_ready, !in_ready, "point taken while busy")
    `PLSQ_ASSERT_NOW(a_count_nonzero, clk, rst_n, out_valid, point_count != '0, "fit with zero points")
    `PLSQ_ASSERT_NOW(a_degen_angle, clk, rst_n, out_valid && degenerate, normal_angle == '0, "degenerate angle")

endmodule

@@ sim/line_fit_checker.sv @@
// Line fit checker: predicts each fit result from the observed transfers and compares.
module line_fit_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic                                cfg_wr_data,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic signed [plsq_pkg::COORD_W-1:0] coord_a,
    input  logic signed [plsq_pkg::COORD_W-1:0] coord_b,
    input  logic                                last_point,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic signed [plsq_pkg::ANG_W-1:0]   normal_angle,
    input  logic signed [plsq_pkg::DIST_W-1:0]  normal_distance,
    input  logic [plsq_pkg::CNT_W-1:0]          point_count,
    input  logic                                degenerate,
    input  logic                                count_overflow,
    output int                                  mismatches,
    output int                                  fits_pending,
    output int                                  fits_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     POINT_LIMIT = 1024;
    localparam int     STAGES      = 16;
    localparam longint HALF_PI     = 64'sd1 << 30;
    localparam longint FULL_PI     = 64'sd1 << 31;
    localparam longint GAIN        = 64'sd652032874;

    typedef struct {
        logic signed [15:0] angle;
        logic signed [16:0] distance;
        logic [10:0]        count;
        logic               degen;
        logic               ovf;
    } fit_t;

    longint atan_tab [STAGES] = '{536870912, 316933406, 167458907, 85004756, 42667331,
        21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861};

    fit_t   fit_queue[$];
    logic   polar_mode;
    longint acc_x, acc_y, acc_xx, acc_yy, acc_xy;
    int     acc_n;
    logic   acc_ovf;

    assign fits_pending = fit_queue.size();

    function automatic void cordic_rotate(input longint zin, output longint c,
                                          output longint s);
        longint x, y, z, nx;
        bit     flip;
        x = GAIN; y = 0; z = zin; flip = 1'b0;
        if (z > HALF_PI) begin z -= FULL_PI; flip = 1'b1; end
        else if (z < -HALF_PI) begin z += FULL_PI; flip = 1'b1; end
        for (int i = 0; i < STAGES; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i); y = y + (x >>> i); z -= atan_tab[i];
            end else begin
                nx = x + (y >>> i); y = y - (x >>> i); z += atan_tab[i];
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic longint cordic_atan2(input longint xin, input longint yin);
        longint x, y, z, nx, t;
        x = xin; y = yin; z = 0;
        if (x < 0) begin
            if (y >= 0) begin t = x; x = y; y = -t; z = HALF_PI; end
            else begin t = x; x = -y; y = t; z = -HALF_PI; end
        end
        for (int i = 0; i < STAGES; i++) begin
            if (y > 0) begin
                nx = x + (y >>> i); y = y - (x >>> i); z += atan_tab[i];
            end else begin
                nx = x - (y >>> i); y = y + (x >>> i); z -= atan_tab[i];
            end
            x = nx;
        end
        return z;
    endfunction

    function automatic longint scale_coord(input longint r, input longint c);
        longint v;
        v = (r * c + (64'sd1 << 29)) >>> 30;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v;
    endfunction

    // Accumulate one point; returns 1 with the fit when the point closes a segment.
    function automatic bit fit_point(input longint a, input longint b, input bit last,
                                     output fit_t res);
        longint x, y, c, s, n, cxx, cyy, cxy, ax, ay, alpha, num, d;
        longint unsigned mx, my, mn, den, q;
        bit degen;
        if (polar_mode) begin
            if (b < 0) b = 0;
            cordic_rotate(a * 65536, c, s);
            x = scale_coord(b, c);
            y = scale_coord(b, s);
        end else begin
            x = a; y = b;
        end
        if (acc_n < POINT_LIMIT) begin
            acc_x += x; acc_y += y;
            acc_xx += x * x; acc_yy += y * y; acc_xy += x * y;
            acc_n++;
        end else
            acc_ovf = 1'b1;
        if (!last) return 1'b0;

        n   = acc_n;
        cxx = n * acc_xx - acc_x * acc_x;
        cyy = n * acc_yy - acc_y * acc_y;
        cxy = n * acc_xy - acc_x * acc_y;
        ax  = cyy - cxx;
        ay  = 0 - 2 * cxy;
        degen = (ax == 0 && ay == 0);
        if (degen)
            alpha = 0;
        else begin
            mx = ax < 0 ? -ax : ax;
            my = ay < 0 ? -ay : ay;
            while ((mx | my) >= (64'd1 << 30)) begin mx >>= 1; my >>= 1; end
            alpha = (cordic_atan2(ax < 0 ? -longint'(mx) : longint'(mx),
                                  ay < 0 ? -longint'(my) : longint'(my)) + 65536) >>> 17;
        end
        cordic_rotate(alpha * 65536, c, s);
        num = acc_x * c + acc_y * s;
        den = longint'(n) << 30;
        mn  = num < 0 ? -num : num;
        q   = (mn + den / 2) / den;
        if (q > 65536) q = 65536;
        d = num < 0 ? -longint'(q) : longint'(q);
        if (d > 65535) d = 65535;

        res.angle    = alpha[15:0];
        res.distance = d[16:0];
        res.count    = acc_n[10:0];
        res.degen    = degen;
        res.ovf      = acc_ovf;
        acc_x = 0; acc_y = 0; acc_xx = 0; acc_yy = 0; acc_xy = 0;
        acc_n = 0; acc_ovf = 1'b0;
        return 1'b1;
    endfunction

    task automatic report(input string field, input longint got, input longint want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        fit_t res, want;
        if (!rst_n) begin
            polar_mode = 1'b0;
            acc_x = 0; acc_y = 0; acc_xx = 0; acc_yy = 0; acc_xy = 0;
            acc_n = 0; acc_ovf = 1'b0;
            mismatches = 0;
            fits_seen = 0;
            fit_queue.delete();
        end else begin
            if (out_valid && out_ready) begin
                fits_seen++;
                if (fit_queue.size() == 0)
                    report("unexpected result", normal_angle, 0);
                else begin
                    want = fit_queue.pop_front();
                    if (normal_angle !== want.angle)
                        report("normal_angle", normal_angle, want.angle);
                    if (normal_distance !== want.distance)
                        report("normal_distance", normal_distance, want.distance);
                    if (point_count !== want.count)
                        report("point_count", point_count, want.count);
                    if (degenerate !== want.degen)
                        report("degenerate", degenerate, want.degen);
                    if (count_overflow !== want.ovf)
                        report("count_overflow", count_overflow, want.ovf);
                end
            end
            if (in_valid && in_ready)
                if (fit_point(coord_a, coord_b, last_point, res))
                    fit_queue = {fit_queue, res};
            if (cfg_wr_en)
                polar_mode = cfg_wr_data;
        end
    end
endmodule

@@ sim/testbench.sv @@
// Top-level testbench for the polar line fit block: stimulus, flow control and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk = 0, rst_n = 0;
    logic cfg_wr_en = 0, cfg_wr_data = 0;
    logic in_valid = 0, in_ready;
    logic signed [plsq_pkg::COORD_W-1:0] coord_a = 0, coord_b = 0;
    logic last_point = 0;
    logic out_valid, out_ready = 0;
    logic signed [plsq_pkg::ANG_W-1:0]  normal_angle;
    logic signed [plsq_pkg::DIST_W-1:0] normal_distance;
    logic [plsq_pkg::CNT_W-1:0]         point_count;
    logic degenerate, count_overflow;
    int   mismatches, fits_pending, fits_seen;
    int   points_sent = 0;
    bit   quiet = 0;

    always begin
        #5 clk = 1;
        #5 clk = 0;
    end

    polar_least_squares_line_fit dut (.*);
    line_fit_checker checker_i (.*);

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver stalls
    always @(posedge clk) begin
        int hold;
        if (!rst_n) out_ready <= 1'b0;
        else if (hold > 0) hold--;
        else begin
            hold = gap_len();
            out_ready <= (hold == 0);
            if (hold > 0) hold--;
        end
    end

    task automatic send_point(input int a, input int b, input bit last);
        int g;
        in_valid   <= 1'b1;
        coord_a    <= a[15:0];
        coord_b    <= b[15:0];
        last_point <= last;
        do @(posedge clk); while (!in_ready);
        points_sent++;
        g = gap_len();
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // Wait out all fits plus the tail of any point still in flight, then switch mode.
    task automatic set_mode(input bit m);
        in_valid <= 1'b0;
        @(posedge clk);
        while (fits_pending != 0) @(posedge clk);
        repeat (150) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_segment(input bit polar, input int len);
        int x0, y0, dx, dy, noise;
        x0 = $urandom_range(0, 65535) - 32768;
        y0 = $urandom_range(0, 65535) - 32768;
        dx = $urandom_range(0, 400) - 200;
        dy = $urandom_range(0, 400) - 200;
        noise = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30);
        for (int i = 0; i < len; i++) begin
            int a, b;
            if ($urandom_range(0, 4) == 0) begin
                a = $urandom_range(0, 65535) - 32768;
                b = $urandom_range(0, 65535) - 32768;
            end else if (polar) begin
                a = x0 + i * dx / 4 + $urandom_range(0, 2 * noise) - noise;
                b = $urandom_range(0, 32767);
            end else begin
                a = x0 + i * dx + $urandom_range(0, 2 * noise) - noise;
                b = y0 + i * dy + $urandom_range(0, 2 * noise) - noise;
            end
            a = a > 32767 ? 32767 : (a < -32768 ? -32768 : a);
            b = b > 32767 ? 32767 : (b < -32768 ? -32768 : b);
            send_point(a, b, i == len - 1);
        end
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Cartesian: single point, extremes, flat line, isotropic square
        send_point(1234, -77, 1);
        send_point(32767, 32767, 0);
        send_point(-32768, -32768, 1);
        send_point(-32768, 32767, 0);
        send_point(32767, -32768, 1);
        send_point(-500, 100, 0);
        send_point(0, 100, 0);
        send_point(700, 100, 1);
        send_point(10, 10, 0);
        send_point(-10, 10, 0);
        send_point(-10, -10, 0);
        send_point(10, -10, 1);

        set_mode(1);
        send_point(0, 32767, 1);
        send_point(-32768, 32767, 0);
        send_point(32767, 32767, 0);
        send_point(16384, -5, 1);
        send_point(8192, 20000, 0);
        send_point(-16384, -32768, 0);
        send_point(5000, 1000, 1);

        set_mode(0);
        // overfull segment, the extra points are dropped
        quiet = 1;
        for (int i = 0; i < 1030; i++)
            send_point($urandom_range(0, 65535) - 32768, i * 13 - 6000, i == 1029);
        quiet = 0;

        for (int ph = 0; ph < 8; ph++) begin
            bit polar;
            int sent_here;
            polar = ph[0];
            set_mode(polar);
            quiet = (ph == 5);
            sent_here = 0;
            while (sent_here < 28) begin
                int len;
                len = $urandom_range(0, 9) == 0 ? $urandom_range(20, 60)
                                                : $urandom_range(1, 12);
                random_segment(polar, len);
                sent_here += len;
            end
        end
        in_valid <= 1'b0;
        quiet = 0;

        while (fits_pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        $display("Covered %0d points and %0d fits, Cartesian and polar modes,", points_sent,
                 fits_seen);
        $display("including degenerate scatter, count overflow and extreme coordinates.");
        if (mismatches == 0 && fits_pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #30ms;
        $display("simulation failed");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+design
design/plsq_pkg.sv
design/plsq_ctrl.sv
design/plsq_dp.sv
design/polar_least_squares_line_fit.sv
sim/line_fit_checker.sv
sim/testbench.sv
